/* rtl/kvbs_pkg.sv */
package kvbs_pkg;

    localparam int KVBS_MAX_ENTRIES = 32;
    localparam int KVBS_ENTRY_W     = 6;
    localparam int KVBS_WORD_W      = 32;
    localparam int KVBS_VALUE_W     = 40;

    localparam logic [KVBS_VALUE_W-1:0] KVBS_EST_MAX   = 40'hFF_FFFF_FFFF;
    localparam logic [KVBS_VALUE_W-1:0] KVBS_EST_RESET = 40'd8;
    localparam logic [3:0]              KVBS_WORD_BYTES = 4'd4;

    // Command codes.
    localparam logic [2:0] CMD_BEGIN   = 3'd0;
    localparam logic [2:0] CMD_PAYLOAD = 3'd1;
    localparam logic [2:0] CMD_FINISH  = 3'd2;
    localparam logic [2:0] CMD_RESET   = 3'd3;
    localparam logic [2:0] CMD_EST     = 3'd4;

    // Result kinds.
    localparam logic [2:0] KIND_VARINT  = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD = 3'd1;
    localparam logic [2:0] KIND_WORD    = 3'd2;
    localparam logic [2:0] KIND_EST     = 3'd3;
    localparam logic [2:0] KIND_FULL    = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] key_length;
        logic [31:0] value_length;
        logic [7:0]  data_byte;
    } req_t;

    typedef struct packed {
        logic [KVBS_VALUE_W-1:0] out_value;
        logic [2:0]              out_kind;
        logic                    last;
    } rsp_t;

    // Number of bytes in the varint32 form of a value.
    function automatic logic [2:0] varint_len(input logic [31:0] v);
        logic [2:0] n;
        n = 3'd1;
        if (|v[31:7])  n = n + 3'd1;
        if (|v[31:14]) n = n + 3'd1;
        if (|v[31:21]) n = n + 3'd1;
        if (|v[31:28]) n = n + 3'd1;
        return n;
    endfunction

endpackage

/* rtl/kvbs_ram.sv */
module kvbs_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 33
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/kv_block_serializer_unit.sv */
// Key-value block serializer.
// Requests enter on req (req_valid/req_stall) and results leave on rsp
// (rsp_valid/rsp_stall); a request is taken at an edge with valid high and
// stall low. A begin-entry request stores the current byte offset in the
// restart memory and emits the key and value lengths as 2 to 10 varint32
// bytes, one per cycle unless rsp stalls. A payload request passes its byte
// through; when the output register is free it is taken every cycle and its
// result appears in the next cycle. An estimate request forms a partial sum,
// then emits its saturating sum with the running estimate, left unchanged.
// Finish reads the restart memory from entry zero through the last written
// entry (address state, then the registered read data is emitted), then
// emits the entry count. A request that causes results, except a payload
// taken while the output register is free, is held in the sequencer, so
// req_stall is high from the intake edge until its last result sits in the
// output register. A stalled receiver holds rsp and pauses the sequencer.
// After rst_n the block is empty: no entries, byte count zero, estimate 8.
// The reset request does the same and gives no result. A begin entry into a
// full restart table gives a single table-full result and changes nothing.
module kv_block_serializer_unit
    import kvbs_pkg::*;
#(
    parameter int MAX_ENTRIES = KVBS_MAX_ENTRIES
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int ADDR_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ONE   = 3'd1;
    localparam logic [2:0] S_VAR   = 3'd2;
    localparam logic [2:0] S_EST   = 3'd3;
    localparam logic [2:0] S_FRD   = 3'd4;
    localparam logic [2:0] S_FEMIT = 3'd5;
    localparam logic [2:0] S_FCNT  = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [31:0]             byte_count_reg, byte_count_next;
    logic [KVBS_ENTRY_W-1:0] entry_count_reg, entry_count_next;
    logic [KVBS_VALUE_W-1:0] est_reg, est_next;

    // Working registers of the sequencer.
    logic [31:0]             cur_reg, cur_next;
    logic [31:0]             vlen_reg, vlen_next;
    logic                    phase_reg, phase_next;
    logic [3:0]              nbytes_reg, nbytes_next;
    logic [33:0]             part_reg, part_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic [KVBS_VALUE_W-1:0] one_value_reg, one_value_next;
    logic [2:0]              one_kind_reg, one_kind_next;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;
    logic out_load;
    logic out_free;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [31:0]       rd_data;

    // Saturating sums for the estimate.
    logic [KVBS_VALUE_W:0]   est_plus_one;
    logic [KVBS_VALUE_W:0]   est_plus_entry;
    logic [KVBS_VALUE_W+1:0] est_plus_part;
    logic [3:0]              nbytes_inc;
    logic                    more;
    logic [6:0]              fin_words;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign nbytes_inc     = nbytes_reg + 4'd1;
    assign more           = |cur_reg[31:7];
    assign est_plus_one   = {1'b0, est_reg} + (KVBS_VALUE_W+1)'(1);
    assign est_plus_entry = {1'b0, est_reg} + (KVBS_VALUE_W+1)'(KVBS_WORD_BYTES)
                            + (KVBS_VALUE_W+1)'(nbytes_inc);
    assign est_plus_part  = {2'b0, est_reg} + (KVBS_VALUE_W+2)'(part_reg);
    assign fin_words      = 7'(entry_count_reg) + 7'd2;

    assign wr_addr = ADDR_W'(entry_count_reg + KVBS_ENTRY_W'(1));

    kvbs_ram
    #(
        .WIDTH (KVBS_WORD_W),
        .DEPTH (MAX_ENTRIES + 1)
    )
    u_restart_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (byte_count_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        byte_count_next  = byte_count_reg;
        entry_count_next = entry_count_reg;
        est_next         = est_reg;
        cur_next         = cur_reg;
        vlen_next        = vlen_reg;
        phase_next       = phase_reg;
        nbytes_next      = nbytes_reg;
        part_next        = part_reg;
        idx_next         = idx_reg;
        one_value_next   = one_value_reg;
        one_kind_next    = one_kind_reg;
        out_load         = 1'b0;
        rsp_next         = rsp_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.command)
                        CMD_BEGIN:
                        begin
                            if (entry_count_reg >= KVBS_ENTRY_W'(MAX_ENTRIES))
                            begin
                                one_value_next = '0;
                                one_kind_next  = KIND_FULL;
                                state_next     = S_ONE;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                cur_next    = req.key_length;
                                vlen_next   = req.value_length;
                                phase_next  = 1'b0;
                                nbytes_next = '0;
                                state_next  = S_VAR;
                            end
                        end
                        CMD_PAYLOAD:
                        begin
                            byte_count_next = byte_count_reg + 32'd1;
                            est_next = est_plus_one[KVBS_VALUE_W] ? KVBS_EST_MAX
                                     : est_plus_one[KVBS_VALUE_W-1:0];
                            if (out_free)
                            begin
                                out_load           = 1'b1;
                                rsp_next.out_value = KVBS_VALUE_W'(req.data_byte);
                                rsp_next.out_kind  = KIND_PAYLOAD;
                                rsp_next.last      = 1'b1;
                            end
                            else
                            begin
                                one_value_next = KVBS_VALUE_W'(req.data_byte);
                                one_kind_next  = KIND_PAYLOAD;
                                state_next     = S_ONE;
                            end
                        end
                        CMD_FINISH:
                        begin
                            idx_next   = '0;
                            state_next = S_FRD;
                        end
                        CMD_RESET:
                        begin
                            byte_count_next  = '0;
                            entry_count_next = '0;
                            est_next         = KVBS_EST_RESET;
                        end
                        CMD_EST:
                        begin
                            part_next = 34'(req.key_length) + 34'(req.value_length)
                                      + 34'(KVBS_WORD_BYTES)
                                      + 34'(varint_len(req.key_length))
                                      + 34'(varint_len(req.value_length));
                            state_next = S_EST;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    rsp_next.out_value = one_value_reg;
                    rsp_next.out_kind  = one_kind_reg;
                    rsp_next.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_VAR:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    rsp_next.out_value = KVBS_VALUE_W'({more, cur_reg[6:0]});
                    rsp_next.out_kind  = KIND_VARINT;
                    rsp_next.last      = !more && phase_reg;
                    nbytes_next        = nbytes_inc;
                    if (more)
                    begin
                        cur_next = {7'b0, cur_reg[31:7]};
                    end
                    else if (!phase_reg)
                    begin
                        cur_next   = vlen_reg;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        byte_count_next  = byte_count_reg + 32'(nbytes_inc);
                        entry_count_next = entry_count_reg + KVBS_ENTRY_W'(1);
                        est_next = est_plus_entry[KVBS_VALUE_W] ? KVBS_EST_MAX
                                 : est_plus_entry[KVBS_VALUE_W-1:0];
                        state_next = S_IDLE;
                    end
                end
            end
            S_EST:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    rsp_next.out_value = (|est_plus_part[KVBS_VALUE_W+1:KVBS_VALUE_W])
                                       ? KVBS_EST_MAX : est_plus_part[KVBS_VALUE_W-1:0];
                    rsp_next.out_kind  = KIND_EST;
                    rsp_next.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_FRD:
            begin
                rd_en      = 1'b1;
                state_next = S_FEMIT;
            end
            S_FEMIT:
            begin
                if (out_free)
                begin
                    // Entry zero is never written and always reads as zero.
                    out_load           = 1'b1;
                    rsp_next.out_value = (idx_reg == '0) ? '0 : KVBS_VALUE_W'(rd_data);
                    rsp_next.out_kind  = KIND_WORD;
                    rsp_next.last      = 1'b0;
                    idx_next           = idx_reg + ADDR_W'(1);
                    if (idx_reg == ADDR_W'(entry_count_reg))
                    begin
                        state_next = S_FCNT;
                    end
                    else
                    begin
                        state_next = S_FRD;
                    end
                end
            end
            S_FCNT:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    rsp_next.out_value = KVBS_VALUE_W'(entry_count_reg);
                    rsp_next.out_kind  = KIND_WORD;
                    rsp_next.last      = 1'b1;
                    byte_count_next    = byte_count_reg + {23'b0, fin_words, 2'b00};
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            byte_count_reg  <= '0;
            entry_count_reg <= '0;
            est_reg         <= KVBS_EST_RESET;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            byte_count_reg  <= byte_count_next;
            entry_count_reg <= entry_count_next;
            est_reg         <= est_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        vlen_reg      <= vlen_next;
        phase_reg     <= phase_next;
        nbytes_reg    <= nbytes_next;
        part_reg      <= part_next;
        idx_reg       <= idx_next;
        one_value_reg <= one_value_next;
        one_kind_reg  <= one_kind_next;
        rsp_reg       <= rsp_next;
    end

    // The entry count never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= KVBS_ENTRY_W'(MAX_ENTRIES))
        else $error("entry count above table size");

    // The running estimate never drops below its reset value.
    assert property (@(posedge clk) disable iff (!rst_n)
        est_reg >= KVBS_EST_RESET)
        else $error("size estimate below reset value");

    // The finish sweep never reads past the last written entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FRD || state_reg == S_FEMIT)
        |-> (idx_reg <= ADDR_W'(entry_count_reg)))
        else $error("finish index beyond entry count");

    // Two varint32 lengths take at most ten bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VAR) |-> (nbytes_reg < 4'd10))
        else $error("varint byte count overrun");

    // A request is only taken while idle; a taken finish request starts the sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.command == CMD_FINISH) |=> (state_reg == S_FRD))
        else $error("finish request did not start the sweep");

endmodule
